/* design/srfr_pkg.sv */
// Shared types and constants for the servo reply frame receiver.
`default_nettype none

package srfr_pkg;

  // One input beat: a received byte or a time tick.
  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] frame_id;
    logic [7:0] frame_size;
    logic [7:0] command_byte;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] expected_sum;
    logic [7:0] received_sum;
  } out_item_t;

  // Result kinds.
  localparam logic [2:0] KIND_FACTOR  = 3'd0;
  localparam logic [2:0] KIND_GOOD    = 3'd1;
  localparam logic [2:0] KIND_BADSUM  = 3'd2;
  localparam logic [2:0] KIND_SHORT   = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;

  // Input modes.
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Header byte and timeout reset value.
  localparam logic [7:0]  HEADER_BYTE   = 8'hFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd300;

  // Receiver phases.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ID,
    PH_SIZE,
    PH_CMD,
    PH_BODY
  } phase_t;

endpackage

`default_nettype wire

/* design/srfr_stage.sv */
// One-entry register stage with valid and stall handshake.
`default_nettype none

module srfr_stage #(
  parameter type payload_t = logic [7:0]
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire payload_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output payload_t      out_data
);

  logic load;
  logic valid_next;

  // The stage stalls only while it holds a beat that cannot leave.
  assign in_stall   = out_valid && out_stall;
  assign load       = in_valid && !in_stall;
  assign valid_next = load || (out_valid && out_stall);

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_next;
    end
  end

  // Payload register, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= in_data;
    end
  end

endmodule

`default_nettype wire

/* design/srfr_core.sv */
// Frame receiver state machine: one step per input beat.
`default_nettype none

module srfr_core
  import srfr_pkg::*;
#(
  parameter int HEADER_LENGTH = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire in_item_t    item,
  input  wire logic [15:0] timeout_ticks,
  output logic             has_result,
  output out_item_t        result
);

  localparam int HW = $clog2(HEADER_LENGTH + 1);
  localparam logic [HW:0] HEADER_LEN_C = (HW + 1)'(HEADER_LENGTH);

  phase_t        phase, phase_next;
  logic [HW-1:0] header_seen, header_seen_next;
  logic [7:0]    held_id, held_id_next;
  logic [7:0]    held_size, held_size_next;
  logic [7:0]    held_command, held_command_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [7:0]    bytes_left, bytes_left_next;
  logic [7:0]    factor_count, factor_count_next;
  logic [15:0]   elapsed_ticks, elapsed_ticks_next;

  logic          restart;
  logic          emit;
  logic [2:0]    emit_kind;
  logic [7:0]    exp_sum;
  logic [16:0]   tick_inc;
  logic [HW:0]   header_inc;
  logic [7:0]    left_dec;

  assign exp_sum    = HEADER_BYTE - running_sum;
  assign tick_inc   = {1'b0, elapsed_ticks} + 17'd1;
  assign header_inc = {1'b0, header_seen} + {{HW{1'b0}}, 1'b1};
  assign left_dec   = bytes_left - 8'd1;

  // Next state: the updates of one step, before any restart of the hunt.
  always_comb begin
    phase_next         = phase;
    header_seen_next   = header_seen;
    held_id_next       = held_id;
    held_size_next     = held_size;
    held_command_next  = held_command;
    running_sum_next   = running_sum;
    bytes_left_next    = bytes_left;
    factor_count_next  = factor_count;
    elapsed_ticks_next = elapsed_ticks;
    restart            = 1'b0;
    emit               = 1'b0;
    emit_kind          = KIND_FACTOR;
    if (item.mode == MODE_TICK) begin
      // Ticks count only once the first header byte has been seen.
      if (!(phase == PH_HUNT && header_seen == '0)) begin
        if (tick_inc > {1'b0, timeout_ticks}) begin
          emit      = 1'b1;
          emit_kind = KIND_TIMEOUT;
          restart   = 1'b1;
        end else begin
          elapsed_ticks_next = tick_inc[15:0];
        end
      end
    end else begin
      case (phase)
        PH_HUNT: begin
          if (item.rx_byte == HEADER_BYTE) begin
            if (header_inc >= HEADER_LEN_C) begin
              header_seen_next = '0;
              phase_next       = PH_ID;
            end else begin
              header_seen_next = header_inc[HW-1:0];
            end
          end else begin
            restart = 1'b1;
          end
        end
        PH_ID: begin
          held_id_next     = item.rx_byte;
          running_sum_next = item.rx_byte;
          phase_next       = PH_SIZE;
        end
        PH_SIZE: begin
          held_size_next   = item.rx_byte;
          running_sum_next = running_sum + item.rx_byte;
          if (item.rx_byte == 8'd0) begin
            emit      = 1'b1;
            emit_kind = KIND_SHORT;
            restart   = 1'b1;
          end else begin
            bytes_left_next = item.rx_byte;
            phase_next      = PH_CMD;
          end
        end
        PH_CMD: begin
          held_command_next = item.rx_byte;
          running_sum_next  = running_sum + item.rx_byte;
          bytes_left_next   = left_dec;
          if (left_dec == 8'd0) begin
            emit      = 1'b1;
            emit_kind = KIND_SHORT;
            restart   = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          emit = 1'b1;
          if (bytes_left <= 8'd1) begin
            // Last byte of the frame is the checksum.
            emit_kind = (exp_sum == item.rx_byte) ? KIND_GOOD : KIND_BADSUM;
            restart   = 1'b1;
          end else begin
            emit_kind         = KIND_FACTOR;
            running_sum_next  = running_sum + item.rx_byte;
            factor_count_next = factor_count + 8'd1;
            bytes_left_next   = left_dec;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
    end
  end

  // Result: frame fields as they stand after this step's updates.
  always_comb begin
    has_result          = emit;
    result              = '0;
    result.kind         = emit_kind;
    result.frame_id     = held_id_next;
    result.frame_size   = held_size_next;
    result.command_byte = held_command_next;
    if (emit_kind == KIND_FACTOR) begin
      result.data_byte  = item.rx_byte;
      result.byte_index = factor_count;
    end
    if (emit_kind == KIND_GOOD || emit_kind == KIND_BADSUM) begin
      result.expected_sum = exp_sum;
      result.received_sum = item.rx_byte;
    end
  end

  // State registers; a restart clears the whole frame context.
  always_ff @(posedge clk) begin
    if (rst || (fire && restart)) begin
      phase         <= PH_HUNT;
      header_seen   <= '0;
      held_id       <= '0;
      held_size     <= '0;
      held_command  <= '0;
      running_sum   <= '0;
      bytes_left    <= '0;
      factor_count  <= '0;
      elapsed_ticks <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      header_seen   <= header_seen_next;
      held_id       <= held_id_next;
      held_size     <= held_size_next;
      held_command  <= held_command_next;
      running_sum   <= running_sum_next;
      bytes_left    <= bytes_left_next;
      factor_count  <= factor_count_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

endmodule

`default_nettype wire

/* design/servo_reply_frame_receiver.sv */
// A result beat passes through the input register and then the result register,
// and a stalled result register holds the step back.
// Throughput: one input beat per cycle while results flow; while a result beat is
// stalled the input register holds one more beat and the input then stalls.
// Reset (rst, synchronous): clears all valid flags and the frame state, and sets
// timeout_ticks to 300. No clearing pass is needed.
`default_nettype none

module servo_reply_frame_receiver
  import srfr_pkg::*;
#(
  parameter int HEADER_LENGTH = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic        item_valid;
  in_item_t    item;
  logic        res_block;
  logic        fire;
  logic        has_result;
  out_item_t   result;
  logic [15:0] timeout_ticks;

  // Timeout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  // Input register.
  srfr_stage #(.payload_t(in_item_t)) u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_item),
    .out_valid(item_valid),
    .out_stall(res_block),
    .out_data (item)
  );

  // A step runs whenever an input beat is held and the result register can take a beat.
  assign fire = item_valid && !res_block;

  srfr_core #(.HEADER_LENGTH(HEADER_LENGTH)) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (item),
    .timeout_ticks(timeout_ticks),
    .has_result   (has_result),
    .result       (result)
  );

  // Result register.
  srfr_stage #(.payload_t(out_item_t)) u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fire && has_result),
    .in_stall (res_block),
    .in_data  (result),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_item)
  );

endmodule

`default_nettype wire

/* design/srfr_checker.sv */
// Port-level checks for the servo reply frame receiver, bound to the top level.
`default_nettype none

module srfr_checker
  import srfr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed");

  // Only factor beats carry a data byte or an index.
  a_factor_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != KIND_FACTOR |->
      out_item.data_byte == 8'd0 && out_item.byte_index == 8'd0)
    else $error("data byte outside a factor beat");

  // Checksum fields appear only at a checked frame end.
  a_sum_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != KIND_GOOD && out_item.kind != KIND_BADSUM |->
      out_item.expected_sum == 8'd0 && out_item.received_sum == 8'd0)
    else $error("checksum fields outside frame end");

  // A good frame has matching sums, a bad one does not.
  a_good_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_GOOD |->
      out_item.expected_sum == out_item.received_sum)
    else $error("good frame with mismatched checksum");

  a_bad_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_BADSUM |->
      out_item.expected_sum != out_item.received_sum)
    else $error("checksum mismatch reported on matching sums");

endmodule

bind servo_reply_frame_receiver srfr_checker u_srfr_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);

`default_nettype wire

/* verif/frame_checker.sv */
// Beat monitor, frame predictor and result scoreboard for the servo reply frame receiver.
module frame_checker
  import srfr_pkg::*;
#(
  parameter int HEADER_LENGTH = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire in_item_t    in_item,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire out_item_t   out_item,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  output int               fail_count,
  output int               pending,
  output int               good_frames,
  output int               bad_frames,
  output int               timeouts_seen,
  output int               factor_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted receiver state.
  phase_t      rx_phase;
  int          hdr_count;
  logic [7:0]  id_q;
  logic [7:0]  size_q;
  logic [7:0]  cmd_q;
  logic [7:0]  sum_q;
  logic [7:0]  left_q;
  logic [7:0]  factor_idx;
  logic [15:0] ticks_q;
  logic [15:0] timeout_q;

  // Results still owed by the block, oldest first.
  out_item_t   owed_results[$];
  int          errors = 0;
  int          n_good = 0;
  int          n_bad = 0;
  int          n_timeout = 0;
  int          n_factor = 0;

  // Drop any frame in progress and go back to hunting for a header.
  task automatic clear_frame();
    rx_phase   = PH_HUNT;
    hdr_count  = 0;
    id_q       = '0;
    size_q     = '0;
    cmd_q      = '0;
    sum_q      = '0;
    left_q     = '0;
    factor_idx = '0;
    ticks_q    = '0;
  endtask

  // Queue one expected result, tagged with the frame fields held so far.
  task automatic owe_result(input logic [2:0] kind, input logic [7:0] data,
                            input logic [7:0] idx, input logic [7:0] want_sum,
                            input logic [7:0] got_sum);
    out_item_t res;
    res.kind         = kind;
    res.frame_id     = id_q;
    res.frame_size   = size_q;
    res.command_byte = cmd_q;
    res.data_byte    = data;
    res.byte_index   = idx;
    res.expected_sum = want_sum;
    res.received_sum = got_sum;
    owed_results.insert(owed_results.size(), res);
  endtask

  // Advance the predicted deframer by one accepted input beat.
  task automatic take_beat(input in_item_t beat);
    logic [16:0] next_ticks;
    logic [7:0]  want_sum;
    logic [7:0]  b;
    b = beat.rx_byte;
    // A tick only counts once a header byte has been seen.
    if (beat.mode == MODE_TICK) begin
      if (rx_phase == PH_HUNT && hdr_count == 0) return;
      next_ticks = {1'b0, ticks_q} + 17'd1;
      if (next_ticks > {1'b0, timeout_q}) begin
        owe_result(KIND_TIMEOUT, '0, '0, '0, '0);
        clear_frame();
      end else begin
        ticks_q = next_ticks[15:0];
      end
      return;
    end
    case (rx_phase)
      PH_HUNT: begin
        if (b == HEADER_BYTE) begin
          hdr_count++;
          if (hdr_count >= HEADER_LENGTH) begin
            hdr_count = 0;
            rx_phase  = PH_ID;
          end
        end else begin
          clear_frame();
        end
      end
      PH_ID: begin
        id_q     = b;
        sum_q    = b;
        rx_phase = PH_SIZE;
      end
      PH_SIZE: begin
        size_q = b;
        sum_q  = sum_q + b;
        if (b == 8'd0) begin
          owe_result(KIND_SHORT, '0, '0, '0, '0);
          clear_frame();
        end else begin
          left_q   = b;
          rx_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_q  = b;
        sum_q  = sum_q + b;
        left_q = left_q - 8'd1;
        if (left_q == 8'd0) begin
          owe_result(KIND_SHORT, '0, '0, '0, '0);
          clear_frame();
        end else begin
          rx_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        // The last byte of the body is the checksum, the rest are factors.
        if (left_q <= 8'd1) begin
          want_sum = 8'hFF - sum_q;
          owe_result((want_sum == b) ? KIND_GOOD : KIND_BADSUM, '0, '0, want_sum, b);
          clear_frame();
        end else begin
          owe_result(KIND_FACTOR, b, factor_idx, '0, '0);
          sum_q      = sum_q + b;
          factor_idx = factor_idx + 8'd1;
          left_q     = left_q - 8'd1;
        end
      end
      default: clear_frame();
    endcase
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch: expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Compare one accepted result beat with the oldest owed result.
  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (owed_results.size() == 0) begin
      errors++;
      $display("%0t ns: result beat with nothing expected: expected none, actual %h",
               $time, got);
      return;
    end
    want = owed_results.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("frame_id", want.frame_id, got.frame_id);
    check_field("frame_size", want.frame_size, got.frame_size);
    check_field("command_byte", want.command_byte, got.command_byte);
    check_field("data_byte", want.data_byte, got.data_byte);
    check_field("byte_index", want.byte_index, got.byte_index);
    check_field("expected_sum", want.expected_sum, got.expected_sum);
    check_field("received_sum", want.received_sum, got.received_sum);
    case (want.kind)
      KIND_GOOD:               n_good++;
      KIND_BADSUM, KIND_SHORT: n_bad++;
      KIND_TIMEOUT:            n_timeout++;
      default:                 n_factor++;
    endcase
  endtask

  // Sample both channels and the register port at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      timeout_q = TIMEOUT_RESET;
      owed_results.delete();
    end else begin
      if (out_valid && !out_stall) compare_result(out_item);
      if (cfg_wr_en) timeout_q = cfg_wr_data;
      if (in_valid && !in_stall) take_beat(in_item);
    end
    fail_count    <= errors;
    pending       <= owed_results.size();
    good_frames   <= n_good;
    bad_frames    <= n_bad;
    timeouts_seen <= n_timeout;
    factor_beats  <= n_factor;
  end

endmodule

/* verif/tb_top.sv */
// Stimulus, clocking and verdict for the servo reply frame receiver testbench.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import srfr_pkg::*;

  localparam int HDR_LEN         = 3;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int BYTES_PER_PHASE = 210;
  localparam int SETTLE_CYCLES   = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int fail_count;
  int pending;
  int good_frames;
  int bad_frames;
  int timeouts_seen;
  int factor_beats;

  // Idling odds: a burst starts with chance 1 in (odds + 1); zero means none.
  int gap_odds = 0;
  int stall_odds = 0;
  int tick_odds = 0;
  int bytes_sent = 0;
  int ticks_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  int stall_left = 0;

  always #5 clk = ~clk;

  servo_reply_frame_receiver #(.HEADER_LENGTH(HDR_LEN)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  frame_checker #(.HEADER_LENGTH(HDR_LEN)) checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .good_frames   (good_frames),
    .bad_frames    (bad_frames),
    .timeouts_seen (timeouts_seen),
    .factor_beats  (factor_beats)
  );

  // Result side backpressure in random bursts.
  always @(negedge clk) begin
    if (stall_left == 0 && stall_odds != 0 && $urandom_range(0, stall_odds) == 0)
      stall_left = $urandom_range(1, 7);
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Present one beat, possibly after an idle burst, and hold it until taken.
  task automatic drive_beat(input logic mode, input logic [7:0] value);
    in_item_t beat;
    beat.mode    = mode;
    beat.rx_byte = value;
    if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (mode == MODE_BYTE) bytes_sent++;
    else ticks_sent++;
  endtask

  // Send a byte, sometimes preceded by a few ticks.
  task automatic send_byte(input logic [7:0] value);
    if (tick_odds != 0 && $urandom_range(0, tick_odds) == 0)
      repeat ($urandom_range(1, 3)) drive_beat(MODE_TICK, 8'($urandom_range(0, 255)));
    drive_beat(MODE_BYTE, value);
  endtask

  // Let the block drain, then write the timeout register.
  task automatic set_timeout(input logic [15:0] ticks);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ticks;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // One random sequence: mostly whole frames, some cut short, some line noise.
  task automatic send_sequence();
    logic [7:0] seq[$];
    logic [7:0] size_b;
    logic [7:0] sum_b;
    logic [7:0] data;
    int         choice;
    int         keep;
    choice = $urandom_range(0, 99);
    if (choice < 10) begin
      // Noise, half header bytes, so partial headers get broken.
      repeat ($urandom_range(1, 6)) begin
        data = 8'($urandom_range(0, 255));
        seq.insert(seq.size(), $urandom_range(0, 1) ? HEADER_BYTE : data);
      end
    end else begin
      repeat (HDR_LEN) seq.insert(seq.size(), HEADER_BYTE);
      data = ($urandom_range(0, 7) == 0) ? HEADER_BYTE : 8'($urandom_range(0, 255));
      seq.insert(seq.size(), data);
      sum_b = data;
      // Mostly small frames, a few too short and now and then a long one.
      if ($urandom_range(0, 39) == 0) size_b = 8'($urandom_range(0, 255));
      else if ($urandom_range(0, 9) == 0) size_b = 8'($urandom_range(0, 1));
      else size_b = 8'($urandom_range(2, 10));
      seq.insert(seq.size(), size_b);
      sum_b = sum_b + size_b;
      for (int i = 1; i <= size_b; i++) begin
        data = 8'($urandom_range(0, 255));
        if (i == size_b && size_b >= 2) begin
          // Checksum byte: usually right, sometimes random.
          seq.insert(seq.size(), ($urandom_range(0, 4) == 0) ? data : 8'hFF - sum_b);
        end else begin
          seq.insert(seq.size(), data);
          sum_b = sum_b + data;
        end
      end
      if (choice < 22) begin
        keep = $urandom_range(1, seq.size() - 1);
        while (seq.size() > keep) void'(seq.pop_back());
      end
    end
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  initial begin
    logic [7:0]  opening [0:21] = '{
      8'hFF, 8'hFF, 8'h00,                             // header broken
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,               // id 0xFF, size zero
      8'hFF, 8'hFF, 8'hFF, 8'h7E, 8'h01, 8'h55,        // size one
      8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h03, 8'hFF, 8'h80, // one factor
      8'h7D                                            // good checksum
    };
    logic [15:0] settings [0:5] = '{16'd1, 16'd65535, 16'd3, 16'd300, 16'd12, 16'd0};
    int          target;

    settings[5] = 16'($urandom_range(2, 60));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening at the reset timeout: idle tick, then the frame cases.
    drive_beat(MODE_TICK, 8'hA5);
    foreach (opening[i]) drive_beat(MODE_BYTE, opening[i]);

    // Random phases, one per timeout setting; the last runs without idling.
    target = bytes_sent;
    for (int ph = 0; ph < 6; ph++) begin
      set_timeout(settings[ph]);
      if (ph == 0) begin
        // Shortest timeout: a header byte and two ticks abandon the frame.
        drive_beat(MODE_BYTE, HEADER_BYTE);
        drive_beat(MODE_TICK, 8'h00);
        drive_beat(MODE_TICK, 8'hFF);
      end
      gap_odds   = (ph == 5 || ph == 3) ? 0 : $urandom_range(2, 10);
      stall_odds = (ph == 5 || ph == 2) ? 0 : $urandom_range(2, 10);
      tick_odds  = $urandom_range(3, 10);
      target     = target + BYTES_PER_PHASE;
      while (bytes_sent < target) send_sequence();
    end

    // Drain: wait for every owed result, then a few more cycles.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d byte beats and %0d tick beats over %0d timeout settings.",
             bytes_sent, ticks_sent, settings_used);
    $display("Results: %0d factors, %0d good frames, %0d bad or short, %0d timeouts.",
             factor_beats, good_frames, bad_frames, timeouts_seen);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
